@@ rtl/core/trab_pkg.sv @@
package trab_pkg;

  // Field widths
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned COORD_W   = 8;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned DIM_W     = 9;
  localparam int unsigned CFG_IDX_W = 2;

  // Edge values over a 256x256 box stay within +/-130050
  localparam int unsigned EDGE_W = 18;
  // Operand width of the shared multiplier (signed)
  localparam int unsigned MUL_W  = 10;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DRAW  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  // Register reset values
  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

endpackage

@@ rtl/core/trab_if.sv @@
// Command channel: one operation per transfer
interface trab_in_if;
  logic                          valid;
  logic                          ready;
  logic [trab_pkg::FUNC_W-1:0]   func;
  logic [trab_pkg::COORD_W-1:0]  vert_x0;
  logic [trab_pkg::COORD_W-1:0]  vert_y0;
  logic [trab_pkg::COORD_W-1:0]  vert_x1;
  logic [trab_pkg::COORD_W-1:0]  vert_y1;
  logic [trab_pkg::COORD_W-1:0]  vert_x2;
  logic [trab_pkg::COORD_W-1:0]  vert_y2;
  logic [trab_pkg::CHAN_W-1:0]   color_r;
  logic [trab_pkg::CHAN_W-1:0]   color_g;
  logic [trab_pkg::CHAN_W-1:0]   color_b;
  logic [trab_pkg::CHAN_W-1:0]   color_a;

  modport source (
    output valid, func, vert_x0, vert_y0, vert_x1, vert_y1, vert_x2, vert_y2,
           color_r, color_g, color_b, color_a,
    input  ready
  );
  modport sink (
    input  valid, func, vert_x0, vert_y0, vert_x1, vert_y1, vert_x2, vert_y2,
           color_r, color_g, color_b, color_a,
    output ready
  );
endinterface

// Response channel: one result per operation
interface trab_out_if;
  logic                         valid;
  logic                         ready;
  logic [trab_pkg::CHAN_W-1:0]  pixel_r;
  logic [trab_pkg::CHAN_W-1:0]  pixel_g;
  logic [trab_pkg::CHAN_W-1:0]  pixel_b;
  logic [trab_pkg::CHAN_W-1:0]  pixel_a;
  logic                         status;

  modport source (
    output valid, pixel_r, pixel_g, pixel_b, pixel_a, status,
    input  ready
  );
  modport sink (
    input  valid, pixel_r, pixel_g, pixel_b, pixel_a, status,
    output ready
  );
endinterface

// Register write channel
interface trab_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [trab_pkg::CFG_IDX_W-1:0]  idx;
  logic [trab_pkg::DIM_W-1:0]      data;

  modport source (
    output valid, idx, data,
    input  ready
  );
  modport sink (
    input  valid, idx, data,
    output ready
  );
endinterface

@@ rtl/core/triangle_raster_alpha_blend_core.sv @@
// Triangle rasteriser with alpha blending over an on-chip RGBA frame store.
// Channels: in_i takes one command per transfer (write pixel, read pixel,
// draw triangle); out_o returns exactly one result per command; cfg_i writes
// the image width (index 0) and height (index 1). The user must write them
// only while the block idles; the block itself does not enforce this.
// in_i.ready is high only when no command is in progress. A write or read
// runs the address setup on the shared multiplier, then the store access,
// then the result state. A draw sets up an edge function per edge and the
// start address on the shared multiplier, walks the bounding box pixel by
// pixel, drains the read/blend/write path of the store and then enters
// the result state. A box or coordinate beyond the image, or the unused
// code, goes from the accept straight to the result state without
// touching the store.
// The result sits in an output register and in_i.ready returns as it is
// loaded, so a new command is taken only once the previous result is
// loaded. A stalled receiver holds the result there; the following
// command runs up to its result state and waits there.
// Reset clears control state and sets width and height to 256. The frame
// store is not cleared; pixels must be written before they are read or
// blended.
module triangle_raster_alpha_blend_core #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  trab_cfg_if.sink    cfg_i,
  trab_in_if.sink     in_i,
  trab_out_if.source  out_o
);
  import trab_pkg::*;

  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned SUM_W  = 2 * CHAN_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP  = 3'd1;
  localparam logic [2:0] ST_ACCESS = 3'd2;
  localparam logic [2:0] ST_WALK   = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  // Setup steps on the shared multiplier
  localparam logic [2:0] STEP_ADDR = 3'd6;
  localparam logic [2:0] STEP_LAST = 3'd7;

  function automatic logic signed [MUL_W-1:0] sdiff(logic [COORD_W-1:0] p,
                                                     logic [COORD_W-1:0] q);
    return $signed({2'b00, p}) - $signed({2'b00, q});
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [DIM_W-1:0] width_q, height_q;
  logic [DIM_W-1:0] w_eff, h_eff;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.idx == CFG_WIDTH) begin
        width_q <= cfg_i.data;
      end else if (cfg_i.idx == CFG_HEIGHT) begin
        height_q <= cfg_i.data;
      end
    end
  end

  // Saturate to the store geometry
  assign w_eff = ({23'd0, width_q} > 32'(MAX_WIDTH))   ? DIM_W'(MAX_WIDTH)  : width_q;
  assign h_eff = ({23'd0, height_q} > 32'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;

  // ---------------------------------------------------------------------
  // State
  logic [2:0] state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       p1_valid_q, p1_valid_d;
  logic       p2_valid_q, p2_valid_d;
  logic       out_valid_q, out_valid_d;

  // Command payload
  logic [FUNC_W-1:0]  func_q, func_d;
  logic [COORD_W-1:0] vx_q [3];
  logic [COORD_W-1:0] vy_q [3];
  logic [COORD_W-1:0] vx_d [3];
  logic [COORD_W-1:0] vy_d [3];
  logic [CHAN_W-1:0]  col_q [3];
  logic [CHAN_W-1:0]  col_d [3];
  logic [CHAN_W-1:0]  alpha_q, alpha_d;
  logic               err_q, err_d;
  logic [COORD_W-1:0] xmin_q, xmin_d, xmax_q, xmax_d;
  logic [COORD_W-1:0] ymin_q, ymin_d, ymax_q, ymax_d;

  // Walk state
  logic [COORD_W-1:0]     x_q, x_d, y_q, y_d;
  logic signed [EDGE_W-1:0] er_q [3];
  logic signed [EDGE_W-1:0] ec_q [3];
  logic signed [EDGE_W-1:0] er_d [3];
  logic signed [EDGE_W-1:0] ec_d [3];
  logic signed [EDGE_W-1:0] t_q, t_d;
  logic [ADDR_W-1:0]      addr_q, addr_d, row_q, row_d;

  // Shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [2:0]               prev_cnt;
  logic [31:0]              addr_full;

  // Per-edge deltas and start offsets
  logic signed [MUL_W-1:0] dx_w [3];
  logic signed [MUL_W-1:0] dy_w [3];
  logic signed [MUL_W-1:0] relx [3];
  logic signed [MUL_W-1:0] rely [3];

  // Blend pipeline
  logic [ADDR_W-1:0] p1_addr_q, p1_addr_d;
  logic [ADDR_W-1:0] p2_addr_q, p2_addr_d;
  logic [CHAN_W-1:0] p2_alpha_q, p2_alpha_d;
  logic [SUM_W-1:0]  blend_q [3];
  logic [SUM_W-1:0]  blend_d [3];
  logic [CHAN_W-1:0] blend_res [3];

  // Frame store ports
  logic [31:0]       mem_q [DEPTH];
  logic [31:0]       rd_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [31:0]       mem_wdata;

  // Output register
  logic [CHAN_W-1:0] out_r_q, out_g_q, out_b_q, out_a_q;
  logic [CHAN_W-1:0] out_r_d, out_g_d, out_b_d, out_a_d;
  logic              out_st_q, out_st_d;

  logic               accept;
  logic               covered, all_pos, all_neg;
  logic [COORD_W-1:0] in_xmin, in_xmax, in_ymin, in_ymax;

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  // Bounding box of the incoming triangle
  always_comb begin
    in_xmin = (in_i.vert_x0 < in_i.vert_x1) ? in_i.vert_x0 : in_i.vert_x1;
    in_xmin = (in_xmin < in_i.vert_x2) ? in_xmin : in_i.vert_x2;
    in_xmax = (in_i.vert_x0 > in_i.vert_x1) ? in_i.vert_x0 : in_i.vert_x1;
    in_xmax = (in_xmax > in_i.vert_x2) ? in_xmax : in_i.vert_x2;
    in_ymin = (in_i.vert_y0 < in_i.vert_y1) ? in_i.vert_y0 : in_i.vert_y1;
    in_ymin = (in_ymin < in_i.vert_y2) ? in_ymin : in_i.vert_y2;
    in_ymax = (in_i.vert_y0 > in_i.vert_y1) ? in_i.vert_y0 : in_i.vert_y1;
    in_ymax = (in_ymax > in_i.vert_y2) ? in_ymax : in_i.vert_y2;
  end

  // Edge k runs from vertex k to vertex k+1
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dx_w[k] = sdiff(vx_q[(k + 1) % 3], vx_q[k]);
      dy_w[k] = sdiff(vy_q[(k + 1) % 3], vy_q[k]);
      relx[k] = sdiff(xmin_q, vx_q[k]);
      rely[k] = sdiff(ymin_q, vy_q[k]);
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cnt_q)
      3'd0: begin mul_a = relx[0]; mul_b = dy_w[0]; end
      3'd1: begin mul_a = rely[0]; mul_b = dx_w[0]; end
      3'd2: begin mul_a = relx[1]; mul_b = dy_w[1]; end
      3'd3: begin mul_a = rely[1]; mul_b = dx_w[1]; end
      3'd4: begin mul_a = relx[2]; mul_b = dy_w[2]; end
      3'd5: begin mul_a = rely[2]; mul_b = dx_w[2]; end
      STEP_ADDR: begin
        mul_a = $signed({2'b00, ymin_q});
        mul_b = $signed({1'b0, w_eff});
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_d    = mul_a * mul_b;
  assign prev_cnt  = cnt_q - 3'd1;
  assign addr_full = {14'd0, prod_q[17:0]} + {24'd0, xmin_q};

  // Coverage: all edges non-negative or all non-positive
  always_comb begin
    all_pos = 1'b1;
    all_neg = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (ec_q[k] < 0) all_pos = 1'b0;
      if (ec_q[k] > 0) all_neg = 1'b0;
    end
    covered = all_pos || all_neg;
  end

  // Blend stage: dst*255 + (src-dst)*a, one narrow product per channel
  always_comb begin
    logic [CHAN_W-1:0]        dst;
    logic signed [CHAN_W:0]   diff;
    logic signed [SUM_W+1:0]  base;
    logic signed [SUM_W+1:0]  sum;
    logic [SUM_W:0]           quo;
    for (int c = 0; c < 3; c++) begin
      dst  = rd_q[c*CHAN_W +: CHAN_W];
      diff = $signed({1'b0, col_q[c]}) - $signed({1'b0, dst});
      base = $signed({2'b00, dst, 8'd0}) - $signed({10'd0, dst});
      sum  = base + diff * $signed({1'b0, alpha_q});
      blend_d[c] = sum[SUM_W-1:0];
      // Exact x/255 for x below 65535
      quo = {1'b0, blend_q[c]} + {9'd0, blend_q[c][SUM_W-1:CHAN_W]} + 17'd1;
      blend_res[c] = quo[SUM_W-1:CHAN_W];
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    func_d      = func_q;
    vx_d        = vx_q;
    vy_d        = vy_q;
    col_d       = col_q;
    alpha_d     = alpha_q;
    err_d       = err_q;
    xmin_d      = xmin_q;
    xmax_d      = xmax_q;
    ymin_d      = ymin_q;
    ymax_d      = ymax_q;
    x_d         = x_q;
    y_d         = y_q;
    er_d        = er_q;
    ec_d        = ec_q;
    t_d         = t_q;
    addr_d      = addr_q;
    row_d       = row_q;
    p1_valid_d  = 1'b0;
    p1_addr_d   = addr_q;
    p2_valid_d  = p1_valid_q;
    p2_addr_d   = p1_addr_q;
    p2_alpha_d  = rd_q[31:24];
    out_valid_d = out_valid_q && !out_o.ready;
    out_r_d     = out_r_q;
    out_g_d     = out_g_q;
    out_b_d     = out_b_q;
    out_a_d     = out_a_q;
    out_st_d    = out_st_q;
    mem_re      = 1'b0;
    mem_raddr   = addr_q;
    mem_we      = p2_valid_q;
    mem_waddr   = p2_addr_q;
    mem_wdata   = {p2_alpha_q, blend_res[2], blend_res[1], blend_res[0]};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          func_d  = in_i.func;
          vx_d[0] = in_i.vert_x0;
          vy_d[0] = in_i.vert_y0;
          vx_d[1] = in_i.vert_x1;
          vy_d[1] = in_i.vert_y1;
          vx_d[2] = in_i.vert_x2;
          vy_d[2] = in_i.vert_y2;
          col_d[0] = in_i.color_r;
          col_d[1] = in_i.color_g;
          col_d[2] = in_i.color_b;
          alpha_d  = in_i.color_a;
          unique case (in_i.func)
            FUNC_DRAW: begin
              xmin_d = in_xmin;
              xmax_d = in_xmax;
              ymin_d = in_ymin;
              ymax_d = in_ymax;
              err_d  = ({1'b0, in_xmax} >= w_eff) || ({1'b0, in_ymax} >= h_eff);
              cnt_d  = 3'd0;
            end
            FUNC_WRITE, FUNC_READ: begin
              xmin_d = in_i.vert_x0;
              ymin_d = in_i.vert_y0;
              err_d  = ({1'b0, in_i.vert_x0} >= w_eff) ||
                       ({1'b0, in_i.vert_y0} >= h_eff);
              cnt_d  = STEP_ADDR;
            end
            default: err_d = 1'b0;
          endcase
          if (in_i.func == FUNC_NOP) begin
            state_d = ST_DONE;
          end else if (err_d) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SETUP;
          end
        end
      end

      // Edge values at the box corner (draws only) and the start address
      ST_SETUP: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q != 3'd0) begin
          unique case (prev_cnt)
            3'd0, 3'd2, 3'd4: t_d = $signed(prod_q[EDGE_W-1:0]);
            3'd1: begin
              er_d[0] = t_q - $signed(prod_q[EDGE_W-1:0]);
              ec_d[0] = er_d[0];
            end
            3'd3: begin
              er_d[1] = t_q - $signed(prod_q[EDGE_W-1:0]);
              ec_d[1] = er_d[1];
            end
            3'd5: begin
              er_d[2] = t_q - $signed(prod_q[EDGE_W-1:0]);
              ec_d[2] = er_d[2];
            end
            default: begin
              addr_d = ADDR_W'(addr_full);
              row_d  = ADDR_W'(addr_full);
            end
          endcase
        end
        if (cnt_q == STEP_LAST) begin
          x_d     = xmin_q;
          y_d     = ymin_q;
          state_d = (func_q == FUNC_DRAW) ? ST_WALK : ST_ACCESS;
        end
      end

      // Single pixel write or read
      ST_ACCESS: begin
        if (func_q == FUNC_WRITE) begin
          mem_we    = 1'b1;
          mem_waddr = addr_q;
          mem_wdata = {alpha_q, col_q[2], col_q[1], col_q[0]};
        end else begin
          mem_re = 1'b1;
        end
        state_d = ST_DONE;
      end

      // One box pixel per cycle; covered pixels enter the blend path
      ST_WALK: begin
        mem_re     = covered;
        p1_valid_d = covered;
        if (x_q != xmax_q) begin
          x_d    = x_q + 8'd1;
          addr_d = addr_q + ADDR_W'(1);
          for (int k = 0; k < 3; k++) begin
            ec_d[k] = ec_q[k] + EDGE_W'(dy_w[k]);
          end
        end else if (y_q != ymax_q) begin
          x_d    = xmin_q;
          y_d    = y_q + 8'd1;
          row_d  = row_q + ADDR_W'(w_eff);
          addr_d = row_d;
          for (int k = 0; k < 3; k++) begin
            er_d[k] = er_q[k] - EDGE_W'(dx_w[k]);
            ec_d[k] = er_d[k];
          end
        end else begin
          state_d = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        if (!p1_valid_q && !p2_valid_q) state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_st_d    = err_q && (func_q != FUNC_NOP);
          if (func_q == FUNC_READ && !err_q) begin
            out_r_d = rd_q[7:0];
            out_g_d = rd_q[15:8];
            out_b_d = rd_q[23:16];
            out_a_d = rd_q[31:24];
          end else begin
            out_r_d = '0;
            out_g_d = '0;
            out_b_d = '0;
            out_a_d = '0;
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      p1_valid_q  <= p1_valid_d;
      p2_valid_q  <= p2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    vx_q       <= vx_d;
    vy_q       <= vy_d;
    col_q      <= col_d;
    alpha_q    <= alpha_d;
    err_q      <= err_d;
    xmin_q     <= xmin_d;
    xmax_q     <= xmax_d;
    ymin_q     <= ymin_d;
    ymax_q     <= ymax_d;
    x_q        <= x_d;
    y_q        <= y_d;
    er_q       <= er_d;
    ec_q       <= ec_d;
    t_q        <= t_d;
    addr_q     <= addr_d;
    row_q      <= row_d;
    prod_q     <= prod_d;
    p1_addr_q  <= p1_addr_d;
    p2_addr_q  <= p2_addr_d;
    p2_alpha_q <= p2_alpha_d;
    blend_q    <= blend_d;
    out_r_q    <= out_r_d;
    out_g_q    <= out_g_d;
    out_b_q    <= out_b_d;
    out_a_q    <= out_a_d;
    out_st_q   <= out_st_d;
  end

  // Frame store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem_q[mem_raddr];
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.pixel_r = out_r_q;
  assign out_o.pixel_g = out_g_q;
  assign out_o.pixel_b = out_b_q;
  assign out_o.pixel_a = out_a_q;
  assign out_o.status  = out_st_q;

  // ---------------------------------------------------------------------
  // Assertions

  // A command leaves the idle state on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
  else $error("command accepted but sequencer stayed idle");

  // No blend write may collide with a single pixel access
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACCESS |-> !p1_valid_q && !p2_valid_q)
  else $error("blend path busy during pixel access");

  // The result is only produced once the blend path has drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> !p1_valid_q && !p2_valid_q)
  else $error("result raised with blend writes outstanding");

  // The walk stays inside the bounding box
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> x_q >= xmin_q && x_q <= xmax_q &&
                           y_q >= ymin_q && y_q <= ymax_q)
  else $error("walk left the bounding box");

  // A new result only appears out of the result state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
  else $error("result raised outside the result state");

endmodule

@@ tb/sv/trab_frame_checker.sv @@
// Watches the register, command and result channels, keeps its own copy of
// the frame store and the image size, and compares every result transfer
// with the oldest outstanding prediction.
module trab_frame_checker #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  trab_cfg_if  cfg_i,
  trab_in_if   cmd_i,
  trab_out_if  rsp_i,
  output int   fail_cnt_o,
  output int   pend_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import trab_pkg::*;

  localparam int CHAN_MAX = 255;

  // Store word layout: r in the low byte, alpha in the top byte
  typedef struct packed {
    logic [CHAN_W-1:0] a;
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] r;
  } rgba_t;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] a;
    logic              status;
  } px_result_t;

  rgba_t            frame_mem [MAX_WIDTH*MAX_HEIGHT];
  logic [DIM_W-1:0] cfg_w = DIM_RESET;
  logic [DIM_W-1:0] cfg_h = DIM_RESET;
  px_result_t       pending_px [$];

  initial begin
    fail_cnt_o = 0;
    pend_cnt_o = 0;
  end

  // Twice the signed area of (a, p, b); zero on the line through a and b
  function automatic int edge_side(int px, int py, int ax, int ay, int bx, int by);
    return (px - ax) * (by - ay) - (py - ay) * (bx - ax);
  endfunction

  function automatic logic [CHAN_W-1:0] blend_chan(int dst, int src, int alpha);
    return CHAN_W'((dst * (CHAN_MAX - alpha) + src * alpha) / CHAN_MAX);
  endfunction

  // Applies one command to the shadow store and returns its result
  function automatic px_result_t predict_pixel_op(
    input logic [FUNC_W-1:0]             op,
    input logic [2:0][COORD_W-1:0]       vx,
    input logic [2:0][COORD_W-1:0]       vy,
    input rgba_t                         col
  );
    px_result_t res;
    rgba_t      p;
    int         w, h, xl, xh, yl, yh, idx, e0, e1, e2;
    int         xs [3];
    int         ys [3];
    res = '0;
    w = (int'(cfg_w) > int'(MAX_WIDTH))  ? int'(MAX_WIDTH)  : int'(cfg_w);
    h = (int'(cfg_h) > int'(MAX_HEIGHT)) ? int'(MAX_HEIGHT) : int'(cfg_h);
    for (int k = 0; k < 3; k++) begin
      xs[k] = int'(vx[k]);
      ys[k] = int'(vy[k]);
    end
    case (op)
      FUNC_WRITE, FUNC_READ: begin
        if (xs[0] >= w || ys[0] >= h) begin
          res.status = 1'b1;
        end else begin
          idx = ys[0] * w + xs[0];
          if (op == FUNC_WRITE) begin
            frame_mem[idx] = col;
          end else begin
            p     = frame_mem[idx];
            res.r = p.r;
            res.g = p.g;
            res.b = p.b;
            res.a = p.a;
          end
        end
      end
      FUNC_DRAW: begin
        xl = xs[0]; xh = xs[0];
        yl = ys[0]; yh = ys[0];
        for (int k = 1; k < 3; k++) begin
          if (xs[k] < xl) xl = xs[k];
          if (xs[k] > xh) xh = xs[k];
          if (ys[k] < yl) yl = ys[k];
          if (ys[k] > yh) yh = ys[k];
        end
        if (xh >= w || yh >= h) begin
          res.status = 1'b1;
        end else begin
          // Covered when all edges agree in sign, either winding
          for (int y = yl; y <= yh; y++) begin
            for (int x = xl; x <= xh; x++) begin
              e0 = edge_side(x, y, xs[0], ys[0], xs[1], ys[1]);
              e1 = edge_side(x, y, xs[1], ys[1], xs[2], ys[2]);
              e2 = edge_side(x, y, xs[2], ys[2], xs[0], ys[0]);
              if ((e0 >= 0 && e1 >= 0 && e2 >= 0) || (e0 <= 0 && e1 <= 0 && e2 <= 0)) begin
                idx = y * w + x;
                p   = frame_mem[idx];
                p.r = blend_chan(int'(p.r), int'(col.r), int'(col.a));
                p.g = blend_chan(int'(p.g), int'(col.g), int'(col.a));
                p.b = blend_chan(int'(p.b), int'(col.b), int'(col.a));
                frame_mem[idx] = p;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic cmp_field(input string name, input logic [CHAN_W-1:0] want,
                           input logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt_o++;
    end
  endtask

  // Transfers are sampled at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    px_result_t want;
    if (!rst_ni) begin
      cfg_w = DIM_RESET;
      cfg_h = DIM_RESET;
      pending_px.delete();
      pend_cnt_o = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_px.size() == 0) begin
          $error("result transfer with no command outstanding");
          fail_cnt_o++;
        end else begin
          want = pending_px.pop_front();
          cmp_field("pixel_r", want.r, rsp_i.pixel_r);
          cmp_field("pixel_g", want.g, rsp_i.pixel_g);
          cmp_field("pixel_b", want.b, rsp_i.pixel_b);
          cmp_field("pixel_a", want.a, rsp_i.pixel_a);
          cmp_field("status", {{(CHAN_W-1){1'b0}}, want.status},
                    {{(CHAN_W-1){1'b0}}, rsp_i.status});
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.idx)
          CFG_WIDTH:  cfg_w = cfg_i.data;
          CFG_HEIGHT: cfg_h = cfg_i.data;
          default: ;
        endcase
      end
      if (cmd_i.valid && cmd_i.ready) begin
        pending_px.push_back(predict_pixel_op(
          cmd_i.func,
          {cmd_i.vert_x2, cmd_i.vert_x1, cmd_i.vert_x0},
          {cmd_i.vert_y2, cmd_i.vert_y1, cmd_i.vert_y0},
          {cmd_i.color_a, cmd_i.color_b, cmd_i.color_g, cmd_i.color_r}));
      end
      pend_cnt_o = pending_px.size();
    end
  end

endmodule

@@ tb/sv/triangle_raster_alpha_blend_core_tb.sv @@
module triangle_raster_alpha_blend_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trab_pkg::*;

  localparam int unsigned FB_W        = 256;
  localparam int unsigned FB_H        = 256;
  localparam int unsigned HOT         = 10;
  localparam int unsigned RAND_ITEMS  = 560;
  localparam int unsigned PHASES      = 5;
  localparam int unsigned WATCH_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 40;

  // Register indexes the block has no use for
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]  op;
    logic [COORD_W-1:0] x0, y0, x1, y1, x2, y2;
    logic [CHAN_W-1:0]  r, g, b, a;
  } cmd_t;

  logic clk;
  logic rst_n;
  int   fail_cnt;
  int   pend_cnt;

  int unsigned img_w = 256;
  int unsigned img_h = 256;
  int unsigned hx, hy;
  int unsigned src_idle  = 32;
  int unsigned sink_idle = 78;
  int unsigned n_sent    = 0;
  int unsigned stall_cycles;

  // Store words already written, so that nothing unwritten is read or blended
  bit written [FB_W*FB_H];

  int unsigned phase_w [PHASES] = '{256, 20, 1, 511, 131};
  int unsigned phase_h [PHASES] = '{256, 14, 1, 97, 300};

  trab_cfg_if cfg_if ();
  trab_in_if  cmd_if ();
  trab_out_if rsp_if ();

  triangle_raster_alpha_blend_core #(
    .MAX_WIDTH  (FB_W),
    .MAX_HEIGHT (FB_H)
  ) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (cmd_if),
    .out_o  (rsp_if)
  );

  trab_frame_checker #(
    .MAX_WIDTH  (FB_W),
    .MAX_HEIGHT (FB_H)
  ) chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_i      (cfg_if),
    .cmd_i      (cmd_if),
    .rsp_i      (rsp_if),
    .fail_cnt_o (fail_cnt),
    .pend_cnt_o (pend_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random back-pressure
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      rsp_if.ready = ($urandom_range(99) >= sink_idle);
    end
  end

  // Watchdog on cycles without any transfer
  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCH_LIMIT) begin
        $display("[triangle_raster_alpha_blend_core] ERROR");
        $finish;
      end
    end
  end

  function automatic int unsigned min3(int unsigned a, int unsigned b, int unsigned c);
    int unsigned m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic int unsigned max3(int unsigned a, int unsigned b, int unsigned c);
    int unsigned m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic int unsigned coord_near(int unsigned base, int unsigned span,
                                             int unsigned lim);
    int unsigned v;
    v = base + $urandom_range(span - 1);
    return (v < lim) ? v : lim - 1;
  endfunction

  function automatic logic [CHAN_W-1:0] rnd_alpha();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  // One command transfer, with random gaps ahead of it
  task automatic put_cmd(input cmd_t c);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      cmd_if.valid = 1'b0;
      @(negedge clk);
    end
    cmd_if.func    = c.op;
    cmd_if.vert_x0 = c.x0;
    cmd_if.vert_y0 = c.y0;
    cmd_if.vert_x1 = c.x1;
    cmd_if.vert_y1 = c.y1;
    cmd_if.vert_x2 = c.x2;
    cmd_if.vert_y2 = c.y2;
    cmd_if.color_r = c.r;
    cmd_if.color_g = c.g;
    cmd_if.color_b = c.b;
    cmd_if.color_a = c.a;
    cmd_if.valid   = 1'b1;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
    if (c.op == FUNC_WRITE && c.x0 < img_w && c.y0 < img_h)
      written[c.y0 * img_w + c.x0] = 1'b1;
    n_sent++;
  endtask

  // Holds off new commands until every result is back
  task automatic drain();
    @(negedge clk);
    cmd_if.valid = 1'b0;
    while (pend_cnt != 0) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    drain();
    cfg_if.idx   = idx;
    cfg_if.data  = data;
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    @(negedge clk);
    cfg_if.valid = 1'b0;
    if (idx == CFG_WIDTH)  img_w = (data > FB_W) ? FB_W : data;
    if (idx == CFG_HEIGHT) img_h = (data > FB_H) ? FB_H : data;
  endtask

  task automatic put_pixel(input int unsigned x, input int unsigned y);
    cmd_t c;
    c = {FUNC_WRITE, 8'(x), 8'(y), 32'($urandom), 32'($urandom)};
    put_cmd(c);
  endtask

  task automatic put_read(input int unsigned x, input int unsigned y);
    cmd_t c;
    if (x < img_w && y < img_h && !written[y * img_w + x]) put_pixel(x, y);
    c = {FUNC_READ, 8'(x), 8'(y), 32'($urandom), 32'($urandom)};
    put_cmd(c);
  endtask

  // Every unwritten pixel of an in-image box is written first, then the draw goes out
  task automatic put_draw(input int unsigned x0, input int unsigned y0,
                          input int unsigned x1, input int unsigned y1,
                          input int unsigned x2, input int unsigned y2,
                          input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                          input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] a);
    cmd_t        c;
    int unsigned xl, xh, yl, yh;
    xl = min3(x0, x1, x2);
    xh = max3(x0, x1, x2);
    yl = min3(y0, y1, y2);
    yh = max3(y0, y1, y2);
    if (xh < img_w && yh < img_h) begin
      for (int unsigned y = yl; y <= yh; y++)
        for (int unsigned x = xl; x <= xh; x++)
          if (!written[y * img_w + x]) put_pixel(x, y);
    end
    c = {FUNC_DRAW, 8'(x0), 8'(y0), 8'(x1), 8'(y1), 8'(x2), 8'(y2), r, g, b, a};
    put_cmd(c);
  endtask

  task automatic pick_spot(output int unsigned x, output int unsigned y);
    case ($urandom_range(3))
      0: begin
        x = $urandom_range(255);
        y = $urandom_range(255);
      end
      1: begin
        x = $urandom_range(img_w - 1);
        y = $urandom_range(img_h - 1);
      end
      default: begin
        x = coord_near(hx, HOT, img_w);
        y = coord_near(hy, HOT, img_h);
      end
    endcase
  endtask

  task automatic rnd_draw();
    int unsigned x0, y0, x1, y1, x2, y2, ox, oy, s;
    if ((img_w < FB_W || img_h < FB_H) && $urandom_range(7) == 0) begin
      // Box reaching past the image
      x0 = $urandom_range(255); y0 = $urandom_range(255);
      x1 = $urandom_range(255); y1 = $urandom_range(255);
      x2 = $urandom_range(255); y2 = $urandom_range(255);
      if (img_w < FB_W) x1 = $urandom_range(255, img_w);
      else              y2 = $urandom_range(255, img_h);
    end else begin
      if ($urandom_range(3) != 0) begin
        ox = hx; oy = hy; s = HOT;
      end else begin
        ox = $urandom_range(img_w - 1);
        oy = $urandom_range(img_h - 1);
        s  = $urandom_range(6, 1);
      end
      x0 = coord_near(ox, s, img_w); y0 = coord_near(oy, s, img_h);
      x1 = coord_near(ox, s, img_w); y1 = coord_near(oy, s, img_h);
      x2 = coord_near(ox, s, img_w); y2 = coord_near(oy, s, img_h);
      // Some collinear shapes: a row, a column, two coincident vertices
      case ($urandom_range(7))
        0: begin y1 = y0; y2 = y0; end
        1: begin x1 = x0; x2 = x0; end
        2: begin x2 = x1; y2 = y1; end
        default: ;
      endcase
    end
    put_draw(x0, y0, x1, y1, x2, y2, 8'($urandom), 8'($urandom), 8'($urandom),
             rnd_alpha());
  endtask

  task automatic rnd_op();
    cmd_t        c;
    int unsigned pick, x, y;
    pick = $urandom_range(99);
    if (pick < 28) begin
      pick_spot(x, y);
      put_pixel(x, y);
    end else if (pick < 50) begin
      pick_spot(x, y);
      put_read(x, y);
    end else if (pick < 93) begin
      rnd_draw();
    end else begin
      c = {FUNC_NOP, 80'({$urandom, $urandom, $urandom})};
      put_cmd(c);
    end
  endtask

  initial begin
    cmd_t        c;
    int unsigned rnd_base, ph_end, done_rnd;
    bit          squeezed;

    cmd_if.valid = 1'b0;
    cmd_if.func  = FUNC_WRITE;
    {cmd_if.vert_x0, cmd_if.vert_y0, cmd_if.vert_x1, cmd_if.vert_y1} = '0;
    {cmd_if.vert_x2, cmd_if.vert_y2} = '0;
    {cmd_if.color_r, cmd_if.color_g, cmd_if.color_b, cmd_if.color_a} = '0;
    cfg_if.valid = 1'b0;
    cfg_if.idx   = CFG_WIDTH;
    cfg_if.data  = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: corner triangles in both windings, a line, a point,
    // opaque and transparent alpha, reads, the spare code
    set_reg(CFG_WIDTH, 9'd256);
    set_reg(CFG_HEIGHT, 9'd256);
    put_draw(253, 253, 255, 255, 255, 253, 8'd255, 8'd0, 8'd128, 8'd255);
    put_draw(253, 253, 255, 253, 255, 255, 8'd10, 8'd200, 8'd30, 8'd0);
    put_draw(253, 255, 254, 254, 255, 253, 8'd90, 8'd90, 8'd90, 8'd100);
    put_draw(254, 254, 254, 254, 254, 254, 8'd1, 8'd2, 8'd3, 8'd17);
    put_read(255, 255);
    put_read(254, 254);
    c = {FUNC_NOP, {10{8'hFF}}};
    put_cmd(c);
    c = {FUNC_WRITE, 80'd0};
    put_cmd(c);
    put_read(0, 0);

    // Zero width: everything lands outside the image
    set_reg(CFG_WIDTH, 9'd0);
    put_read(0, 0);
    put_draw(0, 0, 0, 0, 0, 0, 8'd5, 8'd6, 8'd7, 8'd8);

    // Oversized values saturate; spare indexes change nothing
    set_reg(CFG_WIDTH, 9'h1FF);
    set_reg(CFG_HEIGHT, 9'd300);
    set_reg(CFG_SPARE_A, 9'h0AA);
    set_reg(CFG_SPARE_B, 9'h155);
    put_read(253, 253);

    // Coordinates and boxes beyond a narrower, then a one-row image
    set_reg(CFG_WIDTH, 9'd200);
    put_pixel(230, 10);
    put_read(210, 0);
    put_draw(10, 10, 250, 12, 12, 14, 8'd1, 8'd1, 8'd1, 8'd1);
    set_reg(CFG_HEIGHT, 9'd1);
    put_draw(0, 0, 3, 1, 2, 0, 8'd40, 8'd50, 8'd60, 8'd70);

    // Random phases, one image size each
    rnd_base = n_sent;
    for (int ph = 0; ph < PHASES; ph++) begin
      set_reg(CFG_WIDTH, DIM_W'(phase_w[ph]));
      set_reg(CFG_HEIGHT, DIM_W'(phase_h[ph]));
      hx = (img_w > HOT) ? $urandom_range(img_w - HOT) : 0;
      hy = (img_h > HOT) ? $urandom_range(img_h - HOT) : 0;
      ph_end   = rnd_base + (ph + 1) * RAND_ITEMS / PHASES;
      squeezed = 1'b0;
      while (n_sent < ph_end) begin
        done_rnd = n_sent - rnd_base;
        if (done_rnd < RAND_ITEMS / 3) begin
          src_idle = 32; sink_idle = 78;
        end else if (done_rnd < 2 * RAND_ITEMS / 3) begin
          src_idle = 78; sink_idle = 32;
        end else begin
          src_idle = 0; sink_idle = 0;
        end
        // Let the block run dry once mid-phase
        if (!squeezed && n_sent + RAND_ITEMS / PHASES / 2 >= ph_end) begin
          drain();
          squeezed = 1'b1;
        end
        rnd_op();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[triangle_raster_alpha_blend_core] OK");
    end else begin
      $display("[triangle_raster_alpha_blend_core] ERROR");
    end
    $finish;
  end

endmodule
